/* rtl/assert_macros.svh */
// Assertion macros used by the hasher top level.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/sha_pkg.sv */
// Package for the SHA-256 byte stream hasher: types, round constants, functions.
// Used by all modules of the hasher; depends on nothing.
`timescale 1ns / 1ps
package sha_pkg;
  localparam int BlockBytes = 64;
  localparam int LenBits = 61;
  localparam int Rounds = 64;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_ROUND = 7'b0000100,
    S_ADD = 7'b0001000,
    S_PAD = 7'b0010000,
    S_OUT = 7'b0100000,
    S_WAIT = 7'b1000000
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic [5:0] round;
  } rnd_ctl_t;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam byte_t PadByte = 8'h80;

  function automatic word_t rotr(word_t x, int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage

/* rtl/sha_round.sv */
// One SHA-256 round per cycle while busy, with rolling 16-word schedule.
// Depends on sha_pkg; driven by the sequencer in the top level.
`timescale 1ns / 1ps
module sha_round (
  input  logic                clk,
  input  sha_pkg::rnd_ctl_t   ctl,
  input  sha_pkg::word_t      blk_w [16],
  input  sha_pkg::word_t      chain [8],
  output sha_pkg::word_t      vars [8]
);
  sha_pkg::word_t v_r [8];
  sha_pkg::word_t w_r [16];
  sha_pkg::word_t w_cur, s0, s1, t1, t2, x2, x15;

  always_comb begin
    x2 = w_r[14];
    x15 = w_r[1];
    s1 = sha_pkg::rotr(x2, 17) ^ sha_pkg::rotr(x2, 19) ^ (x2 >> 10);
    s0 = sha_pkg::rotr(x15, 7) ^ sha_pkg::rotr(x15, 18) ^ (x15 >> 3);
    w_cur = w_r[0];
    t1 = v_r[7] + (sha_pkg::rotr(v_r[4], 6) ^ sha_pkg::rotr(v_r[4], 11)
         ^ sha_pkg::rotr(v_r[4], 25)) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + sha_pkg::RoundK[ctl.round] + w_cur;
    t2 = (sha_pkg::rotr(v_r[0], 2) ^ sha_pkg::rotr(v_r[0], 13) ^ sha_pkg::rotr(v_r[0], 22))
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      v_r <= chain;
      w_r <= blk_w;
    end else if (ctl.busy) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= s1 + w_r[9] + s0 + w_r[0];
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign vars = v_r;
endmodule

/* rtl/sha256_byte_stream_hasher.sv */
// SHA-256 hasher fed one byte per item; emits the digest as eight words.
// Input item: data_byte with byte_present, end_of_message closes the message.
// Each full 64-byte block runs 64 rounds on the shared round unit, one a cycle,
// after a load step and before an add step; input is not ready meanwhile.
// A byte that does not fill a block is stored in the block buffer without hashing.
// End of message pads with 0x80, zeros and a 64-bit bit length over one block,
// or two when fewer than nine bytes remain free; then eight digest words are
// shown on out_ in order, word 0 first, one per accepted out handshake.
// The first digest word follows the load, rounds and add of the last block.
// While out_valid waits for out_ready, nothing new is taken; the block holds.
// An end with no byte and nothing before hashes the empty message.
// Reset clears length, fill count and the chaining words to initial values;
// the block buffer is undefined until written.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  sha_pkg::state_t state_r, state_nxt;
  sha_pkg::word_t blk_r [16];
  sha_pkg::word_t h_r [8];
  sha_pkg::word_t vars [8];
  logic [5:0] fill_r;
  logic [60:0] len_r;
  logic [5:0] rnd_r;
  logic [2:0] oidx_r;
  logic fin_r;    // compressing final block
  logic second_r; // one more pad block pending
  logic [63:0] bits;
  sha_pkg::rnd_ctl_t ctl;

  assign bits = {len_r, 3'b000};

  assign ctl.start = (state_r == sha_pkg::S_LOAD);
  assign ctl.busy = (state_r == sha_pkg::S_ROUND);
  assign ctl.round = rnd_r;

  sha_round u_round (.clk(clk), .ctl(ctl), .blk_w(blk_r), .chain(h_r), .vars(vars));

  assign in_ready = (state_r == sha_pkg::S_IDLE);
  assign out_valid = (state_r == sha_pkg::S_OUT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index = oidx_r;
  assign out_last_word = (oidx_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_byte_present && fill_r == 6'd63) state_nxt = sha_pkg::S_LOAD;
          else if (in_end_of_message) state_nxt = sha_pkg::S_PAD;
        end
      end
      sha_pkg::S_LOAD: state_nxt = sha_pkg::S_ROUND;
      sha_pkg::S_ROUND: if (rnd_r == 6'd63) state_nxt = sha_pkg::S_ADD;
      sha_pkg::S_ADD: begin
        if (fin_r) state_nxt = sha_pkg::S_OUT;
        else if (second_r) state_nxt = sha_pkg::S_WAIT;
        else state_nxt = sha_pkg::S_IDLE;
      end
      sha_pkg::S_PAD: state_nxt = sha_pkg::S_LOAD;
      sha_pkg::S_WAIT: state_nxt = sha_pkg::S_LOAD;
      sha_pkg::S_OUT: if (out_ready && oidx_r == 3'd7) state_nxt = sha_pkg::S_IDLE;
      default: state_nxt = sha_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::S_IDLE;
      h_r <= sha_pkg::InitH;
      fill_r <= '0;
      len_r <= '0;
      rnd_r <= '0;
      oidx_r <= '0;
      fin_r <= 1'b0;
      second_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        sha_pkg::S_IDLE: begin
          if (in_valid) begin
            if (in_byte_present) begin
              blk_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= in_data_byte;
              fill_r <= fill_r + 6'd1;
              len_r <= len_r + 61'd1;
            end
            // an end that fills a block is padded in S_WAIT after the full-block pass
            second_r <= in_end_of_message && in_byte_present && fill_r == 6'd63;
          end
        end
        sha_pkg::S_LOAD: rnd_r <= '0;
        sha_pkg::S_ROUND: rnd_r <= rnd_r + 6'd1;
        sha_pkg::S_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + vars[i];
          if (!second_r) fin_r <= 1'b0;
          second_r <= 1'b0;
          oidx_r <= '0;
        end
        sha_pkg::S_WAIT: begin
          // second pad block: marker only when the message ended on a full block
          blk_r[0] <= {(fill_r == 6'd0) ? sha_pkg::PadByte : 8'h00, 24'h000000};
          for (int i = 1; i < 14; i++) blk_r[i] <= '0;
          blk_r[14] <= bits[63:32];
          blk_r[15] <= bits[31:0];
          fin_r <= 1'b1;
        end
        sha_pkg::S_PAD: begin
          for (int i = 0; i < 64; i++) begin
            if (6'(i) == fill_r)
              blk_r[i >> 2][(3 - (i & 3)) * 8 +: 8] <= sha_pkg::PadByte;
            else if (6'(i) > fill_r && (i < 56 || fill_r > 6'd55))
              blk_r[i >> 2][(3 - (i & 3)) * 8 +: 8] <= '0;
          end
          if (fill_r > 6'd55) begin
            second_r <= 1'b1;
            fin_r <= 1'b0;
          end else begin
            blk_r[14] <= bits[63:32];
            blk_r[15] <= bits[31:0];
            fin_r <= 1'b1;
          end
        end
        sha_pkg::S_OUT: begin
          if (out_ready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              h_r <= sha_pkg::InitH;
              fill_r <= '0;
              len_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_out_only_in_out, clk, rst_n, out_valid, !in_ready)
  `ASSERT_NEXT(a_round_advance, clk, rst_n,
    state_r == sha_pkg::S_ROUND && rnd_r != 6'd63, rnd_r == $past(rnd_r) + 6'd1)
  `ASSERT_NEXT(a_last_word_done, clk, rst_n,
    out_valid && out_ready && out_last_word, in_ready)
endmodule
